>>> rtl/ascdp_pkg.sv
// shared types, character codes and arithmetic helpers of the ascii decimal line parser
package ascdp_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [13:0] NON_DIGIT_VALUE = 14'd9999;
  localparam logic [30:0] ACC_MAX         = 31'h7FFF_FFFF;
  localparam logic [5:0]  FRAC_COUNT_MAX  = 6'd63;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_LINE = 1'b1;

  // register index of line_mode
  localparam logic REG_LINE_MODE = 1'b0;

  typedef struct packed {
    logic        result_kind;
    logic [5:0]  line_length;
    logic [5:0]  frac_count;
    logic [30:0] frac_value;
    logic [30:0] int_part;
    logic        line_valid;
    logic [13:0] digit_value;
    logic [7:0]  ascii_code;
  } result_t;

  // acc * 10 + digit, saturating at ACC_MAX; times ten as two shifts and an add
  function automatic logic [30:0] mul_add_sat(input logic [30:0] acc, input logic [3:0] digit);
    logic [34:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'b0, digit};
    if (v > {4'b0000, ACC_MAX}) begin
      return ACC_MAX;
    end
    return v[30:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

>>> rtl/ascii_decimal_line_parser.sv
// top level of the ascii decimal line parser: stream ports, input and result registers
//
// usage
//   bytes arrive one per beat on the s_axis group (tdata = rx_byte). results
//   leave on the m_axis group, tuser = result_kind (0 char, 1 line)
//   char mode (line_mode 0): every byte gives one result beat with its code
//   and digit value (9999 for a non-digit)
//   line mode (line_mode 1): bytes build up a line; cr or lf gives one result
//   beat with validity, integer part, fraction value and count, and length.
//   bytes past CAPACITY-1 stored characters are dropped until the terminator
//   each byte is first registered in the input register and then processed into
//   the result register that drives m_axis_tvalid; a low m_axis_tready can hold it
//   throughput: one byte per cycle when not stalled by m_axis_tready; input and
//   result register each hold one beat, so a byte is taken while a result waits
//   when m_axis_tready is low the result register holds, the input register
//   fills and then s_axis_tready drops until the result beat leaves
//   reset empties both registers, clears the parser state and sets line_mode to char mode
//   an apb write of line_mode (address 0) also clears the line parser; write
//   it only while no byte is in flight
module ascii_decimal_line_parser #(
  parameter int CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // apb configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // input beats
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
  // result beats
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [7:0] ascii_code, [21:8] digit_value, [22] line_valid, [53:23] int_part,
  // [84:54] frac_value, [90:85] frac_count, [96:91] line_length, [103:97] zero
  output logic [103:0]  m_axis_tdata,
  output logic          m_axis_tuser    // [0] result_kind
);

  logic               line_mode;
  logic               cfg_clear;

  logic               in_valid_q, in_valid_d;
  logic [7:0]         in_byte_q, in_byte_d;
  logic               out_valid_q, out_valid_d;
  ascdp_pkg::result_t out_q, out_d;

  logic               out_free;
  logic               proc;
  logic               take_in;
  ascdp_pkg::result_t res;
  logic               res_valid;

  ascdp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .line_mode_o (line_mode),
    .clear_o     (cfg_clear)
  );

  // the byte in the input register is processed once the result register can take its beat
  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || proc;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  ascdp_parser #(
    .CAPACITY (CAPACITY)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_clear),
    .line_mode_i (line_mode),
    .step_i      (proc),
    .byte_i      (in_byte_q),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (take_in) begin
      in_valid_d = 1'b1;
      in_byte_d  = s_axis_tdata;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (proc && res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.result_kind;
  assign m_axis_tdata  = {7'b0, out_q.line_length, out_q.frac_count, out_q.frac_value,
                          out_q.int_part, out_q.line_valid, out_q.digit_value,
                          out_q.ascii_code};

endmodule

>>> rtl/ascdp_cfg.sv
// apb register block holding the line_mode setting
module ascdp_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        line_mode_o,
  output logic        clear_o
);

  logic line_mode_q, line_mode_d;
  logic wr_en;

  assign pready = 1'b1;
  // word index sits in paddr[2]
  assign wr_en  = psel && penable && pwrite && (paddr[2] == ascdp_pkg::REG_LINE_MODE);

  always_comb begin
    line_mode_d = line_mode_q;
    if (wr_en) begin
      line_mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q <= ascdp_pkg::MODE_CHAR;
    end else begin
      line_mode_q <= line_mode_d;
    end
  end

  assign prdata      = (paddr[2] == ascdp_pkg::REG_LINE_MODE) ? {31'b0, line_mode_q} : 32'b0;
  assign line_mode_o = line_mode_q;
  assign clear_o     = wr_en;

endmodule

>>> rtl/ascdp_parser.sv
// line parser state and per-byte result logic
module ascdp_parser #(
  parameter int CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                line_mode_i,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output ascdp_pkg::result_t  res_o,
  output logic                res_valid_o
);

  localparam int CNT_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CAPACITY - 1);

  logic [CNT_W-1:0] char_count_q, char_count_d;
  logic             seen_sep_q, seen_sep_d;
  logic             still_valid_q, still_valid_d;
  logic [30:0]      int_acc_q, int_acc_d;
  logic [30:0]      frac_acc_q, frac_acc_d;
  logic [5:0]       frac_cnt_q, frac_cnt_d;

  logic             is_term;
  logic             is_sep;
  logic             is_dig;
  logic [3:0]       digit;
  logic [CNT_W+5:0] count_wide;

  assign is_term    = (byte_i == ascdp_pkg::CHAR_CR) || (byte_i == ascdp_pkg::CHAR_LF);
  assign is_sep     = (byte_i == ascdp_pkg::CHAR_DOT) || (byte_i == ascdp_pkg::CHAR_COMMA);
  assign is_dig     = ascdp_pkg::is_digit(byte_i);
  assign digit      = 4'(byte_i - ascdp_pkg::CHAR_ZERO);
  assign count_wide = {6'b0, char_count_q};

  // state update
  always_comb begin
    char_count_d  = char_count_q;
    seen_sep_d    = seen_sep_q;
    still_valid_d = still_valid_q;
    int_acc_d     = int_acc_q;
    frac_acc_d    = frac_acc_q;
    frac_cnt_d    = frac_cnt_q;
    if (clear_i || (step_i && line_mode_i && is_term)) begin
      char_count_d  = '0;
      seen_sep_d    = 1'b0;
      still_valid_d = 1'b1;
      int_acc_d     = '0;
      frac_acc_d    = '0;
      frac_cnt_d    = '0;
    end else if (step_i && line_mode_i && (char_count_q < CNT_LIMIT)) begin
      char_count_d = char_count_q + 1'b1;
      if (still_valid_q) begin
        if (is_sep) begin
          if (seen_sep_q) begin
            still_valid_d = 1'b0;
          end else begin
            seen_sep_d = 1'b1;
          end
        end else if (is_dig) begin
          if (!seen_sep_q) begin
            int_acc_d = ascdp_pkg::mul_add_sat(int_acc_q, digit);
          end else begin
            frac_acc_d = ascdp_pkg::mul_add_sat(frac_acc_q, digit);
            if (frac_cnt_q < ascdp_pkg::FRAC_COUNT_MAX) begin
              frac_cnt_d = frac_cnt_q + 1'b1;
            end
          end
        end else begin
          still_valid_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q  <= '0;
      seen_sep_q    <= 1'b0;
      still_valid_q <= 1'b1;
      int_acc_q     <= '0;
      frac_acc_q    <= '0;
      frac_cnt_q    <= '0;
    end else begin
      char_count_q  <= char_count_d;
      seen_sep_q    <= seen_sep_d;
      still_valid_q <= still_valid_d;
      int_acc_q     <= int_acc_d;
      frac_acc_q    <= frac_acc_d;
      frac_cnt_q    <= frac_cnt_d;
    end
  end

  // result of the byte being processed
  always_comb begin
    res_o       = '0;
    res_valid_o = 1'b0;
    if (!line_mode_i) begin
      res_valid_o       = 1'b1;
      res_o.result_kind = ascdp_pkg::KIND_CHAR;
      res_o.ascii_code  = byte_i;
      res_o.digit_value = is_dig ? {10'b0, digit} : ascdp_pkg::NON_DIGIT_VALUE;
    end else if (is_term) begin
      res_valid_o       = 1'b1;
      res_o.result_kind = ascdp_pkg::KIND_LINE;
      res_o.line_valid  = still_valid_q;
      res_o.int_part    = still_valid_q ? int_acc_q : '0;
      res_o.frac_value  = still_valid_q ? frac_acc_q : '0;
      res_o.frac_count  = frac_cnt_q;
      res_o.line_length = count_wide[5:0];
    end
  end

endmodule
